// ===== design/tli_pkg.sv =====
package tli_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned MagWidth = 65;
  localparam int unsigned QuoWidth = 35;

  typedef enum logic [StatusWidth-1:0] {
    ST_INTERIOR = 2'd0,
    ST_BELOW    = 2'd1,
    ST_ABOVE    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD_LEFT,
    DP_LOAD_RIGHT,
    DP_START_VALUE,
    DP_START_SLOPE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic pos_gt_energy;
    logic span_pos;
  } dp_status_t;

endpackage

// ===== design/table_linear_interpolator.sv =====
// Piecewise linear lookup table, up to TABLE_DEPTH breakpoints held in two
// RAMs. A write word goes into both RAMs as it is accepted. A query word
// scans entries in order, then works with one shared bit-serial divider: it
// divides for the value and the slope when the input lands inside the table,
// for the slope only at either end with two or more points, and not at all
// with one point or on an empty table, which is not scanned. One word at a
// time; a finished result sits in an output register while the next word is
// worked on, and the input stalls while a query is worked on and while its
// result waits behind the one in the output register.
module table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [5:0]  entry_index,
  input  logic [31:0] entry_position,
  input  logic signed [31:0] entry_value,
  input  logic [31:0] query_energy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] interpolated_value,
  output logic signed [31:0] energy_slope,
  output logic [1:0]  lookup_status
);
  import tli_pkg::*;

  localparam int unsigned AddrWidth = $clog2(TABLE_DEPTH);

  logic [6:0]           entries_in_use;
  logic                 busy;
  logic                 accept;
  logic                 wr_en;
  logic [DataWidth-1:0] energy;
  dp_cmd_t              cmd;
  dp_status_t           dstat;
  logic [AddrWidth-1:0] rd_addr;
  logic [DataWidth-1:0] quo_value;
  logic [DataWidth-1:0] rd_value;
  status_t              res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  assign in_ready = !busy;
  assign accept = in_valid && in_ready;
  assign wr_en = accept && command == CMD_WRITE
                 && 32'(entry_index) < 32'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (accept) begin
      energy <= query_energy;
    end
  end

  tli_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(dstat), .wr_en(wr_en),
    .wr_addr(AddrWidth'(entry_index)), .wr_position(entry_position),
    .wr_value(entry_value), .rd_addr(rd_addr), .energy(energy),
    .quo_value(quo_value), .rd_value(rd_value)
  );

  tli_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk(clk), .rst(rst), .go(accept && command == CMD_QUERY),
    .count(entries_in_use), .status(dstat), .quo_value(quo_value),
    .rd_value(rd_value), .out_taken(out_ready), .cmd(cmd),
    .rd_addr(rd_addr), .busy(busy), .res_valid(out_valid),
    .res_value(interpolated_value), .res_slope(energy_slope),
    .res_status(res_status)
  );

  assign lookup_status = res_status;
endmodule

// ===== design/tli_ram.sv =====
module tli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== design/tli_div.sv =====
module tli_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tli_pkg::MagWidth-1:0]  mag,
  input  logic [tli_pkg::DataWidth-1:0] den,
  output logic                          busy,
  output logic [tli_pkg::QuoWidth-1:0]  quo,
  output logic                          rem_nz
);
  import tli_pkg::*;

  localparam int unsigned CntWidth = $clog2(MagWidth + 1);

  logic [MagWidth-1:0]  num;
  logic [DataWidth:0]   rem;
  logic [DataWidth-1:0] dvs;
  logic [CntWidth-1:0]  cnt;
  logic [DataWidth:0]   trial;
  logic [DataWidth:0]   shifted;
  logic [MagWidth-1:0]  qfull;

  assign shifted = {rem[DataWidth-1:0], num[MagWidth-1]};
  assign trial = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CntWidth'(MagWidth);
      num <= mag;
      dvs <= den;
      rem <= '0;
      qfull <= '0;
    end else if (busy) begin
      num <= {num[MagWidth-2:0], 1'b0};
      if (!trial[DataWidth]) begin
        rem <= trial;
        qfull <= {qfull[MagWidth-2:0], 1'b1};
      end else begin
        rem <= shifted;
        qfull <= {qfull[MagWidth-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntWidth'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    if (|qfull[MagWidth-1:QuoWidth-1] && qfull[QuoWidth-2:0] != '0
        || |qfull[MagWidth-1:QuoWidth]) begin
      quo = {1'b1, {(QuoWidth-1){1'b0}}};
    end else begin
      quo = qfull[QuoWidth-1:0];
    end
  end
  assign rem_nz = |rem;
endmodule

// ===== design/tli_datapath.sv =====
module tli_datapath #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tli_pkg::dp_cmd_t                cmd,
  output tli_pkg::dp_status_t             status,
  input  logic                            wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]  wr_addr,
  input  logic [tli_pkg::DataWidth-1:0]   wr_position,
  input  logic [tli_pkg::DataWidth-1:0]   wr_value,
  input  logic [$clog2(TABLE_DEPTH)-1:0]  rd_addr,
  input  logic [tli_pkg::DataWidth-1:0]   energy,
  output logic [tli_pkg::DataWidth-1:0]   quo_value,
  output logic [tli_pkg::DataWidth-1:0]   rd_value
);
  import tli_pkg::*;

  logic [DataWidth-1:0]   rd_pos;
  logic [DataWidth-1:0]   pl;
  logic [DataWidth-1:0]   pr;
  logic signed [DataWidth-1:0] vl;
  logic signed [DataWidth-1:0] vr;
  logic signed [DataWidth:0]   d;
  logic [DataWidth:0]     dmag;
  logic                   dneg;
  logic                   div_start;
  logic [MagWidth-1:0]    div_mag;
  logic [DataWidth-1:0]   div_den;
  logic                   neg_r;
  logic signed [DataWidth-1:0] base_r;
  logic [QuoWidth-1:0]    quo;
  logic                   rem_nz;
  logic                   busy;
  logic signed [QuoWidth+1:0] sq;
  logic signed [QuoWidth+1:0] sum;
  logic [DataWidth-1:0]   mul_a;

  tli_ram #(.WIDTH(DataWidth), .DEPTH(TABLE_DEPTH)) u_pos (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_position),
    .rd_addr(rd_addr), .rd_data(rd_pos)
  );
  tli_ram #(.WIDTH(DataWidth), .DEPTH(TABLE_DEPTH)) u_val (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_value),
    .rd_addr(rd_addr), .rd_data(rd_value)
  );

  tli_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .mag(div_mag), .den(div_den),
    .busy(busy), .quo(quo), .rem_nz(rem_nz)
  );

  assign d = {vr[DataWidth-1], vr} - {vl[DataWidth-1], vl};
  assign dneg = d[DataWidth];
  assign dmag = dneg ? (DataWidth+1)'(0) - d : d;
  assign mul_a = (cmd.op == DP_START_VALUE) ? energy - pl : pl;
  assign div_start = (cmd.op == DP_START_VALUE) || (cmd.op == DP_START_SLOPE);
  assign div_mag = MagWidth'(dmag) * MagWidth'(mul_a);
  assign div_den = pr - pl;

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD_LEFT: begin
        pl <= rd_pos;
        vl <= rd_value;
      end
      DP_LOAD_RIGHT: begin
        pr <= rd_pos;
        vr <= rd_value;
      end
      DP_START_VALUE: begin
        neg_r <= dneg;
        base_r <= vl;
      end
      DP_START_SLOPE: begin
        neg_r <= dneg;
        base_r <= vr;
      end
      default: begin
      end
    endcase
  end

  assign sq = neg_r ? -($signed({2'b00, quo}) + (QuoWidth+2)'(rem_nz))
                    : $signed({2'b00, quo});
  assign sum = sq + (QuoWidth+2)'(base_r);

  always_comb begin
    if (sum > (QuoWidth+2)'(32'sh7fffffff)) begin
      quo_value = 32'h7fffffff;
    end else if (sum < -(QuoWidth+2)'(33'sh080000000)) begin
      quo_value = 32'h80000000;
    end else begin
      quo_value = sum[DataWidth-1:0];
    end
  end

  assign status.div_busy = busy;
  assign status.pos_gt_energy = rd_pos > energy;
  assign status.span_pos = pr > pl;
endmodule

// ===== design/tli_ctrl.sv =====
module tli_ctrl #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [6:0]                      count,
  input  tli_pkg::dp_status_t             status,
  input  logic [tli_pkg::DataWidth-1:0]   quo_value,
  input  logic [tli_pkg::DataWidth-1:0]   rd_value,
  input  logic                            out_taken,
  output tli_pkg::dp_cmd_t                cmd,
  output logic [$clog2(TABLE_DEPTH)-1:0]  rd_addr,
  output logic                            busy,
  output logic                            res_valid,
  output logic [tli_pkg::DataWidth-1:0]   res_value,
  output logic [tli_pkg::DataWidth-1:0]   res_slope,
  output tli_pkg::status_t                res_status
);
  import tli_pkg::*;

  localparam int unsigned AddrWidth = $clog2(TABLE_DEPTH);
  localparam int unsigned IdxWidth = AddrWidth + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_RD_L, S_RD_LW, S_RD_R, S_RD_RW,
    S_VAL, S_VAL_WAIT, S_SLOPE, S_SLOPE_WAIT, S_OUT
  } state_t;

  state_t state;
  logic [IdxWidth-1:0] n;
  logic [IdxWidth-1:0] idx;
  logic [IdxWidth-1:0] left;
  logic                interior;
  logic [IdxWidth-1:0] n_clip;
  logic [DataWidth-1:0] val_r;
  logic [DataWidth-1:0] slope_r;
  status_t             stat_r;
  logic                out_load;

  assign n_clip = (32'(count) > 32'(TABLE_DEPTH)) ? IdxWidth'(TABLE_DEPTH)
                                                  : IdxWidth'(count);
  assign out_load = (state == S_OUT) && (!res_valid || out_taken);

  always_comb begin
    cmd.op = DP_NONE;
    case (state)
      S_RD_R: cmd.op = DP_LOAD_LEFT;
      S_RD_RW: cmd.op = DP_LOAD_RIGHT;
      S_VAL: cmd.op = DP_START_VALUE;
      S_SLOPE: cmd.op = DP_START_SLOPE;
      default: cmd.op = DP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (out_load) begin
        res_valid <= 1'b1;
        res_value <= val_r;
        res_slope <= slope_r;
        res_status <= stat_r;
      end else if (out_taken) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (go) begin
            n <= n_clip;
            idx <= '0;
            rd_addr <= '0;
            if (n_clip == '0) begin
              val_r <= '0;
              slope_r <= '0;
              stat_r <= ST_EMPTY;
              state <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: state <= S_SCAN_WAIT;
        S_SCAN_WAIT: begin
          if (status.pos_gt_energy || idx + 1'b1 == n) begin
            if (status.pos_gt_energy && idx != '0) begin
              stat_r <= ST_INTERIOR;
              interior <= 1'b1;
              left <= idx - 1'b1;
            end else if (status.pos_gt_energy) begin
              stat_r <= ST_BELOW;
              interior <= 1'b0;
              left <= '0;
              val_r <= rd_value;
            end else begin
              stat_r <= ST_ABOVE;
              interior <= 1'b0;
              left <= idx - 1'b1;
              val_r <= rd_value;
            end
            slope_r <= '0;
            if (status.pos_gt_energy && idx != '0 || n >= IdxWidth'(2)) begin
              state <= S_RD_L;
            end else begin
              state <= S_OUT;
            end
          end else begin
            idx <= idx + 1'b1;
            rd_addr <= AddrWidth'(idx + 1'b1);
            state <= S_SCAN;
          end
        end
        S_RD_L: begin
          rd_addr <= AddrWidth'(left);
          state <= S_RD_LW;
        end
        S_RD_LW: begin
          rd_addr <= AddrWidth'(left + 1'b1);
          state <= S_RD_R;
        end
        S_RD_R: state <= S_RD_RW;
        S_RD_RW: state <= interior ? S_VAL : S_SLOPE;
        S_VAL: state <= S_VAL_WAIT;
        S_VAL_WAIT: begin
          if (!status.div_busy) begin
            val_r <= quo_value;
            state <= S_SLOPE;
          end
        end
        S_SLOPE: state <= S_SLOPE_WAIT;
        S_SLOPE_WAIT: begin
          if (!status.div_busy) begin
            slope_r <= status.span_pos ? quo_value : '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTHESIS
  a_idle_no_cmd: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> cmd.op == DP_NONE) else $error("cmd while idle");
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && go && n_clip == '0) |=> stat_r == ST_EMPTY)
    else $error("empty status");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_WAIT |-> idx < n) else $error("scan overrun");
`endif
endmodule

// ===== bench/tb_table_linear_interpolator.sv =====
`timescale 1ns / 100ps

module tb_table_linear_interpolator;
  import tli_pkg::*;

  localparam int Depth = 64;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct {
    logic signed [31:0] value;
    logic signed [31:0] slope;
    status_t            status;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_WRITE;
  logic [5:0]  entry_index = '0;
  logic [31:0] entry_position = '0;
  logic signed [31:0] entry_value = '0;
  logic [31:0] query_energy = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] interpolated_value;
  logic signed [31:0] energy_slope;
  logic [1:0]  lookup_status;

  table_linear_interpolator u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .entry_index(entry_index),
    .entry_position(entry_position), .entry_value(entry_value),
    .query_energy(query_energy),
    .out_valid(out_valid), .out_ready(out_ready),
    .interpolated_value(interpolated_value), .energy_slope(energy_slope),
    .lookup_status(lookup_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the table and the count register
  logic [31:0]        tbl_pos [Depth];
  logic signed [31:0] tbl_val [Depth];
  logic [6:0]         count_reg;

  lookup_t lookup_q[$];
  int errors = 0;
  int n_writes = 0, n_queries = 0, n_results = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int burst_left = 0;
  int unsigned cycle_count = 0;
  int hold_req = 0;
  int hold_left = 0;
  int rx_mode = 0;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint floor_quot(longint unsigned mag, bit neg,
                                        longint unsigned den);
    longint unsigned q;
    q = mag / den;
    if (neg && (mag % den) != 0) q++;
    if (q > (64'd1 << 34)) q = 64'd1 << 34;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint segment_slope(int a, int b);
    longint unsigned p1, p2, ad;
    longint v1, v2, d;
    p1 = tbl_pos[a];
    p2 = tbl_pos[b];
    v1 = tbl_val[a];
    v2 = tbl_val[b];
    if (p2 <= p1) return 0;
    d = v2 - v1;
    ad = (d < 0) ? -d : d;
    return sat32(v2 + floor_quot(ad * p1, d < 0, p2 - p1));
  endfunction

  function automatic lookup_t predict_lookup(logic [31:0] energy);
    lookup_t r;
    int n, i;
    longint unsigned pl, pr, ad;
    longint vl, d;
    n = (count_reg > Depth) ? Depth : count_reg;
    r.value = 0;
    r.slope = 0;
    if (n == 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    for (i = 0; i < n; i++)
      if (tbl_pos[i] > energy) break;
    if (i == n) begin
      r.status = ST_ABOVE;
      r.value = tbl_val[n-1];
      if (n >= 2) r.slope = 32'(segment_slope(n - 2, n - 1));
    end else if (i == 0) begin
      r.status = ST_BELOW;
      r.value = tbl_val[0];
      if (n >= 2) r.slope = 32'(segment_slope(0, 1));
    end else begin
      r.status = ST_INTERIOR;
      pl = tbl_pos[i-1];
      pr = tbl_pos[i];
      vl = tbl_val[i-1];
      d = longint'(tbl_val[i]) - vl;
      ad = (d < 0) ? -d : d;
      r.value = 32'(sat32(vl + floor_quot(ad * (longint'(energy) - pl), d < 0,
                                          pr - pl)));
      r.slope = 32'(segment_slope(i - 1, i));
    end
    return r;
  endfunction

  task automatic send_word(command_t cmd, logic [5:0] idx, logic [31:0] pos,
                           logic [31:0] val, logic [31:0] energy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= cmd;
    entry_index <= idx;
    entry_position <= pos;
    entry_value <= val;
    query_energy <= energy;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_WRITE) begin
      tbl_pos[idx] = pos;
      tbl_val[idx] = val;
      n_writes++;
    end else begin
      lookup_q.insert(lookup_q.size(), predict_lookup(energy));
      n_queries++;
    end
  endtask

  task automatic write_entry(int idx, logic [31:0] pos, logic [31:0] val);
    send_word(CMD_WRITE, idx[5:0], pos, val, $urandom);
  endtask

  task automatic query(logic [31:0] energy);
    send_word(CMD_QUERY, 6'($urandom), $urandom, $urandom, energy);
  endtask

  task automatic set_count(logic [6:0] n);
    in_valid <= 1'b0;
    burst_left = 0;
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_reg = n;
  endtask

  // sorted table with random spacing and values
  task automatic fill_sorted(bit wide_values);
    logic [31:0] p;
    p = $urandom_range(0, 1 << 20);
    for (int i = 0; i < Depth; i++) begin
      write_entry(i, p, wide_values ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21));
      p = p + $urandom_range(1, 1 << 25);
    end
  endtask

  function automatic logic [31:0] pick_energy();
    int n, k;
    logic [31:0] lo, hi;
    n = (count_reg > Depth) ? Depth : count_reg;
    if (n == 0) return $urandom;
    k = $urandom_range(0, n - 1);
    lo = tbl_pos[0];
    hi = tbl_pos[n-1];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return tbl_pos[k] + $urandom_range(0, 3) - 1;
      4, 5, 6, 7: return (hi > lo) ? lo + ($urandom % (hi - lo + 1)) : lo;
      8: return $urandom;
      default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  task automatic test_empty_table();
    query(32'h0);
    query(32'hFFFF_FFFF);
  endtask

  task automatic test_extremes();
    write_entry(0, 32'h0001_0000, 32'h7FFF_FFFF);
    write_entry(1, 32'h0002_0000, 32'h8000_0000);
    set_count(1);
    query(32'h0);
    query(32'hFFFF_FFFF);
    set_count(2);
    query(32'h0001_8000);
    query(32'h0002_0000);
    query(32'h0000_FFFF);
    // duplicate position, top of range, then an out of order slot
    write_entry(2, 32'h0002_0000, 32'sd5);
    write_entry(3, 32'hFFFF_FFFF, -32'sd7);
    write_entry(4, 32'h0, 32'sd100);
    set_count(5);
    query(32'h0002_0000);
    query(32'hFFFF_FFFE);
    query(32'hFFFF_FFFF);
    query(32'h0);
  endtask

  task automatic test_full_count();
    fill_sorted(1'b1);
    set_count(7'd127);
    repeat (4) query(pick_energy());
    set_count(7'd64);
    repeat (4) query(pick_energy());
  endtask

  task automatic test_random_phases();
    logic [6:0] n;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0) fill_sorted(ph % 2 == 0);
      case (ph)
        0: n = 2;
        1: n = 127;
        2: n = 1;
        3: n = 0;
        default: n = $urandom_range(2, 80);
      endcase
      set_count(n);
      for (int j = 0; j < 30; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          // mostly value edits, sometimes a random position
          int idx;
          idx = $urandom_range(0, Depth - 1);
          write_entry(idx, ($urandom_range(0, 3) == 0) ? $urandom : tbl_pos[idx], $urandom);
        end else begin
          query(pick_energy());
        end
      end
    end
  endtask

  task automatic test_backpressure();
    set_count(7'd64);
    hold_req = 1500;
    repeat (20) query(pick_energy());
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 300 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) < 7);
        default: out_ready <= ($urandom_range(0, 9) < 2);
      endcase
    end
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    lookup_t x;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (lookup_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: value %0d slope %0d status %0d",
                 $time, interpolated_value, energy_slope, lookup_status);
      end else begin
        x = lookup_q.pop_front();
        status_seen[x.status]++;
        if (interpolated_value !== x.value) begin
          errors++;
          $display("%0t value: expected %0d actual %0d", $time, x.value, interpolated_value);
        end
        if (energy_slope !== x.slope) begin
          errors++;
          $display("%0t slope: expected %0d actual %0d", $time, x.slope, energy_slope);
        end
        if (lookup_status !== x.status) begin
          errors++;
          $display("%0t status: expected %0d actual %0d", $time, x.status, lookup_status);
        end
      end
    end
  end

  initial begin
    count_reg = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_extremes();
    test_full_count();
    test_random_phases();
    test_backpressure();
    in_valid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("%0d writes, %0d lookups, %0d results checked", n_writes, n_queries, n_results);
    $display("interior %0d, below %0d, above %0d, empty %0d, mismatches %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], errors);
    if (errors == 0 && lookup_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
